>>> design/wall_texture_sampler_core_defines.svh
// ----------------------------------------------------------------------------
// Wall texture sampler: assertion macros
// Shared shorthands for the concurrent checks at the end of the core.
// ----------------------------------------------------------------------------
`ifndef WALL_TEXTURE_SAMPLER_CORE_DEFINES_SVH
`define WALL_TEXTURE_SAMPLER_CORE_DEFINES_SVH

// Check sampled on the rising clock edge, switched off while reset is low
`define WTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check sampled on the rising clock edge, also during reset
`define WTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/wts_pkg.sv
// ----------------------------------------------------------------------------
// Wall texture sampler package
// Field widths, register indexes, face and command codes of the sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wts_pkg;

  // Field widths
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned PIX_W     = 12;
  localparam int unsigned LADDR_W   = 14;
  localparam int unsigned COLOR_W   = 32;

  // Signed row difference: 20-bit row in Q.8 less a signed 24-bit top
  localparam int unsigned NUM_W = COORD_W + 1;
  // Dividend of the row division: difference times face height
  localparam int unsigned DR_W  = COORD_W + CFG_W;

  // Tile span in map units (power of two), and the bits of one tile in Q.8
  localparam int unsigned TILE_SPAN = 64;
  localparam int unsigned SPAN_BITS = $clog2(TILE_SPAN) + 8;

  // Defaults of the core's parameters
  localparam int unsigned MAX_TEX_SIDE_DEF = 64;
  localparam int unsigned TEXEL_BITS_DEF   = 32;

  // Reset value of every face size register
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_DRAW = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    FACE_NORTH = 2'd0,
    FACE_SOUTH = 2'd1,
    FACE_EAST  = 2'd2,
    FACE_WEST  = 2'd3
  } face_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORTH_WIDTH  = 3'd0,
    REG_SOUTH_WIDTH  = 3'd1,
    REG_EAST_WIDTH   = 3'd2,
    REG_WEST_WIDTH   = 3'd3,
    REG_NORTH_HEIGHT = 3'd4,
    REG_SOUTH_HEIGHT = 3'd5,
    REG_EAST_HEIGHT  = 3'd6,
    REG_WEST_HEIGHT  = 3'd7
  } reg_e;

endpackage

>>> design/wall_texture_sampler_core.sv
// ----------------------------------------------------------------------------
// Wall texture sampler core
// Samples one texel per wall pixel of a raycaster strip from a four-face store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one request per transfer:
//   command 0 loads a texel into the store, command 1 draws one wall pixel.
//   Output channel (out_valid_o / out_ready_i) returns one pixel per draw
//   request; load requests give nothing back. The cfg_* port writes the face
//   width and height registers; the user must write them only while the core
//   holds no request, as the core itself does not enforce this.
//   Throughput: one request per cycle unless the receiver stalls. The
//   pipeline is ten stages deep: face select, one multiply stage (column and
//   row products), seven stages of the row divider (one quotient bit each)
//   and address forming; the single store port is used by loads and draws
//   alike at the last stage, so loads and draws keep their order.
//   Reset clears every stage valid bit and sets all face sizes to 64. The
//   texel store is not cleared and must be loaded before it is read.
//   When the receiver stalls, the whole pipeline holds and in_ready_o drops
//   until the waiting pixel is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "wall_texture_sampler_core_defines.svh"

module wall_texture_sampler_core
  import wts_pkg::*;
#(
  parameter int unsigned MAX_TEX_SIDE = MAX_TEX_SIDE_DEF,
  parameter int unsigned TEXEL_BITS   = TEXEL_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  // Configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,

  // Request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic                 hit_vertical_i,
  input  logic                 facing_right_i,
  input  logic                 facing_down_i,
  input  logic [COORD_W-1:0]   hit_x_i,
  input  logic [COORD_W-1:0]   hit_y_i,
  input  logic signed [COORD_W-1:0] strip_top_i,
  input  logic [COORD_W-1:0]   strip_rows_i,
  input  logic [PIX_W-1:0]     pixel_row_i,
  input  logic [PIX_W-1:0]     pixel_column_i,
  input  logic [LADDR_W-1:0]   load_address_i,
  input  logic [COLOR_W-1:0]   load_texel_i,

  // Pixel channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PIX_W-1:0]     out_x_o,
  output logic [PIX_W-1:0]     out_y_o,
  output logic [COLOR_W-1:0]   color_o
);

  localparam int unsigned DEPTH  = 4 * MAX_TEX_SIDE * MAX_TEX_SIDE;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned NDIV   = CFG_W;       // one quotient bit per stage
  localparam int unsigned NST    = NDIV + 3;    // input, multiply, divide, address
  localparam int unsigned DQ     = NDIV + 1;    // last divider stage
  localparam int unsigned LAST   = NST - 1;     // address stage

  typedef struct packed {
    cmd_e                    cmd;
    logic [PIX_W-1:0]        pix_x;
    logic [PIX_W-1:0]        pix_y;
    logic [ADDR_W-1:0]       addr;
    logic [TEXEL_BITS-1:0]   texel;
    logic                    hit;
    face_e                   face;
    logic [CFG_W-1:0]        wdt;
    logic [CFG_W-1:0]        hgt;
    logic [SPAN_BITS-1:0]    rem;
    logic signed [NUM_W-1:0] num;
    logic [COORD_W-1:0]      whgt;
    logic [CFG_W-1:0]        tcol;
    logic                    col_ok;
    logic                    zero_md;
    logic                    full_md;
    logic [DR_W-1:0]         dr;
    logic [CFG_W-1:0]        quot;
  } stage_t;

  logic [CFG_W-1:0]      wid_q [4];
  logic [CFG_W-1:0]      hgt_q [4];
  stage_t                st_q  [NST];
  stage_t                st_d  [NST];
  logic [NST-1:0]        vld_q;
  logic                  adv;
  logic [TEXEL_BITS-1:0] texel_mem [DEPTH];
  logic [TEXEL_BITS-1:0] rd_q;
  logic                  out_vld_q;
  logic                  out_hit_q;
  logic [PIX_W-1:0]      out_x_q;
  logic [PIX_W-1:0]      out_y_q;

  // Whole pipeline moves unless a finished pixel waits at the output
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // Face size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int f = 0; f < 4; f++) begin
        wid_q[f] <= CFG_RESET;
        hgt_q[f] <= CFG_RESET;
      end
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_NORTH_WIDTH:  wid_q[FACE_NORTH] <= cfg_wdata_i;
        REG_SOUTH_WIDTH:  wid_q[FACE_SOUTH] <= cfg_wdata_i;
        REG_EAST_WIDTH:   wid_q[FACE_EAST]  <= cfg_wdata_i;
        REG_WEST_WIDTH:   wid_q[FACE_WEST]  <= cfg_wdata_i;
        REG_NORTH_HEIGHT: hgt_q[FACE_NORTH] <= cfg_wdata_i;
        REG_SOUTH_HEIGHT: hgt_q[FACE_SOUTH] <= cfg_wdata_i;
        REG_EAST_HEIGHT:  hgt_q[FACE_EAST]  <= cfg_wdata_i;
        REG_WEST_HEIGHT:  hgt_q[FACE_WEST]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage logic
  always_comb begin
    logic [COORD_W-1:0]           coord;
    logic [31:0]                  ld_ext;
    logic [SPAN_BITS+CFG_W-1:0]   cprod;
    logic [DR_W-1:0]              dvs;
    logic [CFG_W-1:0]             rowc;
    logic [CFG_W-1:0]             rowr;
    logic [31:0]                  addr_full;
    int unsigned                  bi;

    for (int k = 1; k < NST; k++) begin
      st_d[k] = st_q[k-1];
    end

    // Input stage: face choice, tile remainder, row difference
    st_d[0]       = st_q[0];
    st_d[0].cmd   = cmd_e'(command_i);
    st_d[0].pix_x = pixel_column_i;
    st_d[0].pix_y = pixel_row_i;
    st_d[0].texel = load_texel_i[TEXEL_BITS-1:0];
    ld_ext        = 32'(load_address_i);
    st_d[0].addr  = ld_ext[ADDR_W-1:0];
    st_d[0].hit   = ld_ext < 32'(DEPTH);
    if (hit_vertical_i) begin
      st_d[0].face = facing_right_i ? FACE_WEST : FACE_EAST;
    end else begin
      st_d[0].face = facing_down_i ? FACE_NORTH : FACE_SOUTH;
    end
    st_d[0].wdt  = wid_q[st_d[0].face];
    st_d[0].hgt  = hgt_q[st_d[0].face];
    coord        = hit_vertical_i ? hit_y_i : hit_x_i;
    st_d[0].rem  = coord[SPAN_BITS-1:0];
    st_d[0].num  = $signed({5'b0, pixel_row_i, 8'b0})
                 - $signed({strip_top_i[COORD_W-1], strip_top_i});
    st_d[0].whgt = strip_rows_i;

    // Multiply stage: texture column, row dividend and row mode
    cprod          = st_q[0].rem * st_q[0].wdt;
    st_d[1].tcol   = cprod[SPAN_BITS +: CFG_W];
    st_d[1].col_ok = st_q[0].wdt != '0;
    st_d[1].zero_md = (st_q[0].whgt == '0) || st_q[0].num[NUM_W-1] || (st_q[0].num == '0);
    st_d[1].full_md = st_q[0].num[COORD_W-1:0] >= st_q[0].whgt;
    st_d[1].dr     = st_q[0].num[COORD_W-1:0] * st_q[0].hgt;
    st_d[1].quot   = '0;

    // Restoring divider, one quotient bit per stage, most significant first
    for (int j = 0; j < NDIV; j++) begin
      bi  = NDIV - 1 - j;
      dvs = DR_W'(st_q[j+1].whgt) << bi;
      if (st_q[j+1].dr >= dvs) begin
        st_d[j+2].dr       = st_q[j+1].dr - dvs;
        st_d[j+2].quot[bi] = 1'b1;
      end
    end

    // Address stage: row clamp, range check, store address
    if (st_q[DQ].zero_md) begin
      rowc = '0;
    end else if (st_q[DQ].full_md) begin
      rowc = st_q[DQ].hgt;
    end else begin
      rowc = st_q[DQ].quot;
    end
    rowr = (rowc >= st_q[DQ].hgt) ? st_q[DQ].hgt - 1'b1 : rowc;
    addr_full = 32'(st_q[DQ].face) * 32'(MAX_TEX_SIDE * MAX_TEX_SIDE)
              + 32'(rowr) * 32'(MAX_TEX_SIDE) + 32'(st_q[DQ].tcol);
    if (st_q[DQ].cmd == CMD_DRAW) begin
      st_d[LAST].addr = addr_full[ADDR_W-1:0];
      st_d[LAST].hit  = st_q[DQ].col_ok && (st_q[DQ].hgt != '0)
                     && (32'(st_q[DQ].tcol) < 32'(MAX_TEX_SIDE))
                     && (32'(rowr) < 32'(MAX_TEX_SIDE));
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // Texel store: loads write and draws read at the same stage
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (vld_q[LAST] && st_q[LAST].cmd == CMD_LOAD && st_q[LAST].hit) begin
        texel_mem[st_q[LAST].addr] <= st_q[LAST].texel;
      end
      rd_q <= texel_mem[st_q[LAST].addr];
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_x_q   <= st_q[LAST].pix_x;
      out_y_q   <= st_q[LAST].pix_y;
      out_hit_q <= st_q[LAST].hit;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[LAST] && (st_q[LAST].cmd == CMD_DRAW);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign color_o     = out_hit_q ? COLOR_W'(rd_q) : '0;

  // Checks
  `WTS_ASSERT_ALWAYS(a_reset_no_pixel, !rst_ni |-> !out_valid_o, "pixel valid during reset")
  `WTS_ASSERT(a_stall_holds_pipe, out_valid_o && !out_ready_i |=> $stable(vld_q), "pipeline moved while output stalled")
  `WTS_ASSERT(a_load_no_pixel, adv && vld_q[LAST] && st_q[LAST].cmd == CMD_LOAD |=> !out_valid_o, "load request produced a pixel")
  `WTS_ASSERT(a_div_bounds, vld_q[DQ] && st_q[DQ].cmd == CMD_DRAW && !st_q[DQ].zero_md && !st_q[DQ].full_md |-> (st_q[DQ].hgt == '0 || st_q[DQ].quot < st_q[DQ].hgt) && st_q[DQ].dr < DR_W'(st_q[DQ].whgt), "row divider out of bounds")

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Wall texture sampler testbench
// Sends load and draw requests with random idling on both channels. It keeps
// its own copy of the face sizes and the texel store, predicts each pixel, and
// checks the returned pixels in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import wts_pkg::*;

  localparam int unsigned SIDE          = MAX_TEX_SIDE_DEF;
  localparam int unsigned DEPTH         = 4 * SIDE * SIDE;
  localparam longint      TILE_Q8       = longint'(TILE_SPAN) * 256;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned PHASE_ITEMS   = 160;
  localparam int unsigned IDLE_PCT      = 22;

  typedef struct packed {
    cmd_e                command;
    logic                hit_vertical;
    logic                facing_right;
    logic                facing_down;
    logic [COORD_W-1:0]  hit_x;
    logic [COORD_W-1:0]  hit_y;
    logic [COORD_W-1:0]  strip_top;
    logic [COORD_W-1:0]  strip_rows;
    logic [PIX_W-1:0]    pixel_row;
    logic [PIX_W-1:0]    pixel_column;
    logic [LADDR_W-1:0]  load_address;
    logic [COLOR_W-1:0]  load_texel;
  } request_t;

  typedef struct packed {
    logic [PIX_W-1:0]   x;
    logic [PIX_W-1:0]   y;
    logic [COLOR_W-1:0] color;
  } pixel_t;

  // One row of the directed table: a face size write or a request
  typedef struct packed {
    logic               cfg_row;
    reg_e               cfg_idx;
    logic [CFG_W-1:0]   cfg_val;
    request_t           req;
    logic               has_color;
    logic [COLOR_W-1:0] color;
  } stim_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b1;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 out_ready_i = 1'b0;
  request_t             req_drv     = '0;

  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [PIX_W-1:0]     out_x_o;
  logic [PIX_W-1:0]     out_y_o;
  logic [COLOR_W-1:0]   color_o;

  // Local copy of the sampler state
  logic [CFG_W-1:0]     face_w [4];
  logic [CFG_W-1:0]     face_h [4];
  logic [COLOR_W-1:0]   texel_mem [DEPTH];
  bit                   texel_loaded [DEPTH];

  pixel_t               pixel_q [$];
  int                   fault_count   = 0;
  bit                   steady_flow   = 1'b0;
  logic                 sink_hold_req = 1'b0;

  wall_texture_sampler_core u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .command_i      (req_drv.command),
    .hit_vertical_i (req_drv.hit_vertical),
    .facing_right_i (req_drv.facing_right),
    .facing_down_i  (req_drv.facing_down),
    .hit_x_i        (req_drv.hit_x),
    .hit_y_i        (req_drv.hit_y),
    .strip_top_i    (req_drv.strip_top),
    .strip_rows_i   (req_drv.strip_rows),
    .pixel_row_i    (req_drv.pixel_row),
    .pixel_column_i (req_drv.pixel_column),
    .load_address_i (req_drv.load_address),
    .load_texel_i   (req_drv.load_texel),
    .out_valid_o,
    .out_ready_i,
    .out_x_o,
    .out_y_o,
    .color_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin : watchdog
    #3_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // Store address of the texel a draw reads, or -1 when it reads none
  function automatic int texel_index(input request_t r);
    face_e  face;
    longint w, h, coord, col, num, wh, row;
    if (r.hit_vertical) face = r.facing_right ? FACE_WEST : FACE_EAST;
    else                face = r.facing_down ? FACE_NORTH : FACE_SOUTH;
    w     = longint'(face_w[face]);
    h     = longint'(face_h[face]);
    coord = r.hit_vertical ? longint'(r.hit_y) : longint'(r.hit_x);
    col   = ((coord % TILE_Q8) * w) / TILE_Q8;
    if (col >= w) col = w - 1;
    num = longint'(r.pixel_row) * 256 - longint'($signed(r.strip_top));
    wh  = longint'(r.strip_rows);
    if (wh == 0 || num <= 0) row = 0;
    else if (num >= wh)      row = h;
    else                     row = (num * h) / wh;
    if (row >= h) row = h - 1;
    if (col < 0 || row < 0 || col >= w || row >= h || col >= SIDE || row >= SIDE)
      return -1;
    return int'(longint'(face) * SIDE * SIDE + row * SIDE + col);
  endfunction

  function automatic logic [COLOR_W-1:0] sampled_color(input request_t r);
    int idx;
    idx = texel_index(r);
    return (idx < 0) ? '0 : texel_mem[idx];
  endfunction

  // Every field at random
  function automatic request_t roll_request();
    request_t    r;
    logic [31:0] a, b, c, d, e, f;
    a = $urandom();
    b = $urandom();
    c = $urandom();
    d = $urandom();
    e = $urandom();
    f = $urandom();
    r.command      = cmd_e'(a[31]);
    r.hit_vertical = a[30];
    r.facing_right = a[29];
    r.facing_down  = a[28];
    r.pixel_column = a[27:16];
    r.pixel_row    = a[11:0];
    r.hit_x        = b[23:0];
    r.hit_y        = c[23:0];
    r.strip_top    = d[23:0];
    r.strip_rows   = e[23:0];
    r.load_address = {b[31:24], c[29:24]};
    r.load_texel   = f;
    return r;
  endfunction

  function automatic stim_row_t load_row(input logic [LADDR_W-1:0] addr,
                                         input logic [COLOR_W-1:0] texel);
    stim_row_t s;
    s = '0;
    s.req.command      = CMD_LOAD;
    s.req.load_address = addr;
    s.req.load_texel   = texel;
    return s;
  endfunction

  function automatic stim_row_t draw_row(input logic hv, fr, fd,
                                         input logic [COORD_W-1:0] hx, hy, top, ht,
                                         input logic [PIX_W-1:0] prow, pcol,
                                         input logic has, input logic [COLOR_W-1:0] color);
    stim_row_t s;
    s = '0;
    s.req.command      = CMD_DRAW;
    s.req.hit_vertical = hv;
    s.req.facing_right = fr;
    s.req.facing_down  = fd;
    s.req.hit_x        = hx;
    s.req.hit_y        = hy;
    s.req.strip_top    = top;
    s.req.strip_rows   = ht;
    s.req.pixel_row    = prow;
    s.req.pixel_column = pcol;
    s.has_color        = has;
    s.color            = color;
    return s;
  endfunction

  function automatic stim_row_t face_size_row(input reg_e idx, input logic [CFG_W-1:0] val);
    stim_row_t s;
    s = '0;
    s.cfg_row = 1'b1;
    s.cfg_idx = idx;
    s.cfg_val = val;
    return s;
  endfunction

  // Offer one request, wait for acceptance, then update the local state
  task automatic push_request(input request_t r, input logic has_color,
                              input logic [COLOR_W-1:0] color);
    int     gap;
    pixel_t want;
    gap = 0;
    if (!steady_flow) while ($urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_drv    <= r;
    do @(posedge clk_i); while (!in_ready_o);
    if (r.command == CMD_LOAD) begin
      texel_mem[r.load_address]    = r.load_texel;
      texel_loaded[r.load_address] = 1'b1;
    end else begin
      want.x     = r.pixel_column;
      want.y     = r.pixel_row;
      want.color = has_color ? color : sampled_color(r);
      pixel_q.push_back(want);
    end
  endtask

  // A draw never reads an unloaded texel: load it first with a random colour
  task automatic send_draw(input request_t r, input logic has_color,
                           input logic [COLOR_W-1:0] color);
    int       idx;
    request_t ld;
    idx = texel_index(r);
    if (idx >= 0 && !texel_loaded[idx]) begin
      ld              = roll_request();
      ld.command      = CMD_LOAD;
      ld.load_address = idx[LADDR_W-1:0];
      push_request(ld, 1'b0, '0);
    end
    push_request(r, has_color, color);
  endtask

  // Stop sending until every pixel is back, then let trailing loads retire
  task automatic settle_pipeline();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pixel_q.size() != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_face_reg(input reg_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx[2]) face_h[idx[1:0]] = val;
    else        face_w[idx[1:0]] = val;
  endtask

  // Pixel receiver: checks in order and stalls at random
  initial begin : pixel_sink
    int     hold_left;
    pixel_t want;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pixel_q.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected pixel: x=%0d y=%0d color=%h", out_x_o, out_y_o, color_o);
        end else begin
          want = pixel_q.pop_front();
          if (want.x !== out_x_o || want.y !== out_y_o || want.color !== color_o) begin
            fault_count++;
            if (fault_count <= 10)
              $display("pixel mismatch: expected x=%0d y=%0d color=%h, got x=%0d y=%0d color=%h",
                       want.x, want.y, want.color, out_x_o, out_y_o, color_o);
          end
        end
      end
      // long hold-off so the pipeline fills and back-pressures the requests
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (sink_hold_req) begin
        hold_left = 300;
        sink_hold_req <= 1'b0;
        out_ready_i   <= 1'b0;
      end else begin
        out_ready_i <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    stim_row_t             rows [$];
    logic [7:0][CFG_W-1:0] sizes;
    request_t              r;
    int                    pick, ht, top, pos;

    rst_ni <= 1'b0;
    for (int f = 0; f < 4; f++) begin
      face_w[f] = CFG_RESET;
      face_h[f] = CFG_RESET;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Texels loaded here are read back below with typed colours.
    rows.push_back(load_row(14'd0,     32'hFFFF_FFFF));   // north, row 0, col 0
    rows.push_back(load_row(14'd16383, 32'h8000_0001));   // west, last texel
    rows.push_back(load_row(14'd63,    32'hA5A5_5A5A));   // north, row 0, col 63
    rows.push_back(load_row(14'd4096,  32'h1234_5678));   // south, row 0, col 0
    rows.push_back(load_row(14'd8192,  32'h0000_0001));   // east, row 0, col 0
    // north, lowest coordinate, top row
    rows.push_back(draw_row(1'b0, 1'b0, 1'b1, 24'h0, 24'h0, 24'h0, 24'h4000,
                            12'd0, 12'd0, 1'b1, 32'hFFFF_FFFF));
    // west, last position in the tile, row far below the wall bottom
    rows.push_back(draw_row(1'b1, 1'b1, 1'b0, 24'h0, 24'h003FFF, 24'h0, 24'h000100,
                            12'd4095, 12'd4095, 1'b1, 32'h8000_0001));
    // north, all-ones coordinate wraps to the last column
    rows.push_back(draw_row(1'b0, 1'b0, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'h0, 24'h4000,
                            12'd0, 12'd2048, 1'b1, 32'hA5A5_5A5A));
    // zero wall height gives the top row
    rows.push_back(draw_row(1'b0, 1'b0, 1'b1, 24'h0, 24'h0, 24'h0, 24'h0,
                            12'd2000, 12'd1, 1'b1, 32'hFFFF_FFFF));
    // south, highest wall top: row above the wall
    rows.push_back(draw_row(1'b0, 1'b0, 1'b0, 24'h0, 24'h0, 24'h7FFFFF, 24'h4000,
                            12'd4095, 12'd7, 1'b1, 32'h1234_5678));
    // east, lowest wall top and largest height
    rows.push_back(draw_row(1'b1, 1'b0, 1'b1, 24'h0, 24'h004000, 24'h800000, 24'hFFFFFF,
                            12'd0, 12'd100, 1'b0, '0));
    // row exactly at the wall bottom clamps to the last row
    rows.push_back(draw_row(1'b0, 1'b0, 1'b1, 24'h0, 24'h0, 24'h0, 24'h001000,
                            12'd16, 12'd16, 1'b0, '0));
    // row inside the wall with a fractional top
    rows.push_back(draw_row(1'b0, 1'b0, 1'b1, 24'h001234, 24'h0, 24'h000080, 24'h000A00,
                            12'd5, 12'd5, 1'b0, '0));
    // zero face width reads nothing
    rows.push_back(face_size_row(REG_NORTH_WIDTH, 7'd0));
    rows.push_back(draw_row(1'b0, 1'b0, 1'b1, 24'h0, 24'h0, 24'h0, 24'h4000,
                            12'd0, 12'd0, 1'b1, 32'h0));
    // zero face height reads nothing
    rows.push_back(face_size_row(REG_NORTH_WIDTH, 7'd64));
    rows.push_back(face_size_row(REG_NORTH_HEIGHT, 7'd0));
    rows.push_back(draw_row(1'b0, 1'b0, 1'b1, 24'h0, 24'h0, 24'h0, 24'h4000,
                            12'd0, 12'd0, 1'b1, 32'h0));
    // face larger than the store side: column beyond the store gives black
    rows.push_back(face_size_row(REG_NORTH_WIDTH, 7'd127));
    rows.push_back(face_size_row(REG_NORTH_HEIGHT, 7'd127));
    rows.push_back(draw_row(1'b0, 1'b0, 1'b1, 24'h003FFF, 24'h0, 24'h0, 24'h4000,
                            12'd0, 12'd0, 1'b1, 32'h0));
    rows.push_back(face_size_row(REG_NORTH_WIDTH, 7'd64));
    rows.push_back(face_size_row(REG_NORTH_HEIGHT, 7'd64));

    foreach (rows[i]) begin
      if (rows[i].cfg_row) begin
        settle_pipeline();
        write_face_reg(rows[i].cfg_idx, rows[i].cfg_val);
        cfg_we_i <= 1'b0;
      end else if (rows[i].req.command == CMD_LOAD) begin
        push_request(rows[i].req, 1'b0, '0);
      end else begin
        send_draw(rows[i].req, rows[i].has_color, rows[i].color);
      end
    end

    // Random phases, each with its own face sizes (index 7 down to 0)
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: sizes = {8{CFG_RESET}};
        1: sizes = {8{7'd1}};
        2: sizes = {7'd64, 7'd1, 7'd0, 7'd127, 7'd1, 7'd64, 7'd127, 7'd0};
        3: sizes = {7'd0, 7'd127, 7'd64, 7'd1, 7'd127, 7'd0, 7'd1, 7'd64};
        default: begin
          for (int k = 0; k < 8; k++)
            sizes[k] = ($urandom_range(0, 99) < 70) ? 7'($urandom_range(1, 64))
                                                    : 7'($urandom_range(0, 127));
        end
      endcase
      settle_pipeline();
      steady_flow = (ph == 1);
      for (int k = 0; k < 8; k++) write_face_reg(reg_e'(k), sizes[k]);
      cfg_we_i <= 1'b0;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 100) sink_hold_req <= 1'b1;
        if (ph == 4 && n == 120) settle_pipeline();
        r    = roll_request();
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          // stray load anywhere in the store
          r.command = CMD_LOAD;
          push_request(r, 1'b0, '0);
        end else begin
          r.command = CMD_DRAW;
          if (pick < 70) begin
            // pixel row taken from inside a plausible wall span
            ht  = $urandom_range(256, 1 << 18);
            top = int'($urandom_range(0, 1 << 20)) - (1 << 19);
            pos = top + int'($urandom_range(0, ht - 1));
            r.strip_rows = ht[23:0];
            r.strip_top  = top[23:0];
            r.pixel_row  = (pos <= 0) ? '0 : pos[19:8];
          end else if (pick < 80) begin
            r.strip_rows = '0;
          end
          send_draw(r, 1'b0, '0);
        end
      end
    end

    settle_pipeline();
    if (fault_count == 0 && pixel_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
